// File: sv/pbm_pkg.sv
// Shared types and constants of the prefix blocklist matcher.
package pbm_pkg;

  localparam int unsigned ADDR_W   = 64;
  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned V4_W     = 32;
  localparam int unsigned SEL_W    = 9;

  // Stream payload layout.
  localparam int unsigned S_TDATA_W = 264;
  localparam int unsigned S_TUSER_W = 2;
  localparam int unsigned M_TDATA_W = 8;

  localparam int unsigned SLOT_LSB    = 0;
  localparam int unsigned ADDR_HI_LSB = 4;
  localparam int unsigned ADDR_LO_LSB = 68;
  localparam int unsigned MASK_HI_LSB = 132;
  localparam int unsigned MASK_LO_LSB = 196;

  localparam int unsigned TUSER_ACTION  = 0;
  localparam int unsigned TUSER_VERSION = 1;

  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_QUERY = 1'b1
  } pbm_action_t;

  typedef enum logic {
    VER_V4 = 1'b0,
    VER_V6 = 1'b1
  } pbm_version_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } pbm_state_t;

  typedef struct packed {
    pbm_version_t        version;
    logic [ADDR_W-1:0]   net_hi;
    logic [ADDR_W-1:0]   net_lo;
    logic [ADDR_W-1:0]   mask_hi;
    logic [ADDR_W-1:0]   mask_lo;
  } pbm_entry_t;

  // Controller to datapath.
  typedef struct packed {
    logic write_entry;
    logic start_query;
    logic rd_en;
    logic load_out;
  } pbm_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic scan_done;
    logic out_free;
  } pbm_sts_t;

endpackage

// File: sv/pbm_ctrl.sv
// Controller state machine of the prefix blocklist matcher.
module pbm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  pbm_pkg::pbm_action_t action,
  input  pbm_pkg::pbm_sts_t sts,
  output logic              in_ready,
  output pbm_pkg::pbm_cmd_t cmd
);
  import pbm_pkg::*;

  pbm_state_t state;
  pbm_state_t state_next;
  logic       accept;

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && action == ACT_QUERY) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.scan_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state)
      ST_IDLE: begin
        in_ready        = 1'b1;
        cmd.write_entry = in_valid && action == ACT_LOAD;
        cmd.start_query = in_valid && action == ACT_QUERY;
      end
      ST_SCAN: begin
        cmd.rd_en = !sts.scan_done;
      end
      ST_FINISH: begin
        cmd.load_out = sts.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// File: sv/pbm_datapath.sv
// Prefix table, scan counter, masked compare and result register.
module pbm_datapath #(
  parameter int unsigned TABLE_DEPTH = 16,
  parameter int unsigned IDX_W       = 4,
  parameter int unsigned CNT_W       = 5
) (
  input  logic                            clk,
  input  logic                            rst,
  input  pbm_pkg::pbm_cmd_t               cmd,
  output pbm_pkg::pbm_sts_t               sts,
  input  logic                            cfg_wen,
  input  logic [pbm_pkg::COUNT_W-1:0]     cfg_wdata,
  input  logic [pbm_pkg::SLOT_W-1:0]      slot,
  input  pbm_pkg::pbm_version_t           ip_version,
  input  logic [pbm_pkg::ADDR_W-1:0]      addr_hi,
  input  logic [pbm_pkg::ADDR_W-1:0]      addr_lo,
  input  logic [pbm_pkg::ADDR_W-1:0]      mask_hi,
  input  logic [pbm_pkg::ADDR_W-1:0]      mask_lo,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic                            out_blocked
);
  import pbm_pkg::*;

  localparam logic [SEL_W-1:0] DEPTH_SEL = SEL_W'(TABLE_DEPTH);

  pbm_entry_t         mem [TABLE_DEPTH];
  pbm_entry_t         rdata;
  pbm_entry_t         wentry;
  logic               rd_valid;

  logic [COUNT_W-1:0] entry_count;
  logic [CNT_W-1:0]   n_lim;
  logic [CNT_W-1:0]   n_lim_next;
  logic [CNT_W-1:0]   idx;
  logic [SEL_W-1:0]   count_sel;
  logic [SEL_W-1:0]   slot_sel;
  logic               slot_ok;

  pbm_version_t       q_ver;
  logic [ADDR_W-1:0]  q_hi;
  logic [ADDR_W-1:0]  q_lo;
  logic               hit;
  logic               match;

  assign count_sel  = {{(SEL_W - COUNT_W){1'b0}}, entry_count};
  assign n_lim_next = (count_sel > DEPTH_SEL) ? CNT_W'(TABLE_DEPTH) : CNT_W'(entry_count);
  assign slot_sel   = {{(SEL_W - SLOT_W){1'b0}}, slot};
  assign slot_ok    = slot_sel < DEPTH_SEL;

  assign wentry.version = ip_version;
  assign wentry.net_hi  = addr_hi;
  assign wentry.net_lo  = addr_lo;
  assign wentry.mask_hi = mask_hi;
  assign wentry.mask_lo = mask_lo;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg_wen) begin
      entry_count <= cfg_wdata;
    end
  end

  // Table memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.write_entry && slot_ok) begin
      mem[slot_sel[IDX_W-1:0]] <= wentry;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rdata <= mem[idx[IDX_W-1:0]];
    end
  end

  // Latch the query.
  always_ff @(posedge clk) begin
    if (cmd.start_query) begin
      q_ver <= ip_version;
      q_hi  <= addr_hi;
      q_lo  <= addr_lo;
      n_lim <= n_lim_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx      <= '0;
      rd_valid <= 1'b0;
      hit      <= 1'b0;
    end else begin
      rd_valid <= cmd.rd_en;
      if (cmd.start_query) begin
        idx <= '0;
        hit <= 1'b0;
      end else begin
        if (cmd.rd_en) begin
          idx <= idx + CNT_W'(1);
        end
        if (rd_valid && match) begin
          hit <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    match = 1'b0;
    if (rdata.version == q_ver) begin
      if (q_ver == VER_V4) begin
        match = (q_lo[V4_W-1:0] & rdata.mask_lo[V4_W-1:0]) == rdata.net_lo[V4_W-1:0];
      end else begin
        match = ((q_hi & rdata.mask_hi) == rdata.net_hi) &&
                ((q_lo & rdata.mask_lo) == rdata.net_lo);
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_blocked <= hit;
    end
  end

  assign sts.scan_done = idx == n_lim;
  assign sts.out_free  = !out_valid || out_ready;

endmodule

// File: sv/prefix_blocklist_matcher_core.sv
// Top level of the prefix blocklist matcher: stream ports, controller and datapath.
//
//   channel   dir  handshake                    payload
//   s_axis    in   s_axis_tvalid/s_axis_tready  tdata: slot, addr_hi, addr_lo, mask_hi, mask_lo
//                                               tuser: action, ip_version
//   m_axis    out  m_axis_tvalid/m_axis_tready  tdata: blocked
//   cfg       in   cfg_wen (no backpressure)    cfg_wdata: entry_count
//
// A load beat writes one table slot; the block is ready again at once.
// A query beat scans n = min(entry_count, TABLE_DEPTH) slots: the table memory is read
// one slot per cycle and each entry is checked with one masked compare, 128-bit for IPv6
// and 32-bit for IPv4. The result waits in an output register, so the next beat is taken
// while it is unread; a stalled m_axis holds the following query in its finish state only.
// rst is synchronous; it clears entry_count and all control state. Table contents are
// left as they were and must be loaded before a slot in use is queried.
module prefix_blocklist_matcher_core #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [3:0] slot, [67:4] addr_hi, [131:68] addr_lo, [195:132] mask_hi,
  // [259:196] mask_lo, [263:260] zero
  input  logic [pbm_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  // [0] action, [1] ip_version
  input  logic [pbm_pkg::S_TUSER_W-1:0]     s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [0] blocked, [7:1] zero
  output logic [pbm_pkg::M_TDATA_W-1:0]     m_axis_tdata,
  input  logic                              cfg_wen,
  input  logic [pbm_pkg::COUNT_W-1:0]       cfg_wdata
);
  import pbm_pkg::*;

  // Slot index covers the table; counter also holds the depth itself.
  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  pbm_cmd_t     cmd;
  pbm_sts_t     sts;
  pbm_action_t  action;
  pbm_version_t ip_version;
  logic         blocked;

  // Unpack the input beat.
  assign action     = pbm_action_t'(s_axis_tuser[TUSER_ACTION]);
  assign ip_version = pbm_version_t'(s_axis_tuser[TUSER_VERSION]);

  pbm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .action   (action),
    .sts      (sts),
    .in_ready (s_axis_tready),
    .cmd      (cmd)
  );

  pbm_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .IDX_W       (IDX_W),
    .CNT_W       (CNT_W)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_wen     (cfg_wen),
    .cfg_wdata   (cfg_wdata),
    .slot        (s_axis_tdata[SLOT_LSB +: SLOT_W]),
    .ip_version  (ip_version),
    .addr_hi     (s_axis_tdata[ADDR_HI_LSB +: ADDR_W]),
    .addr_lo     (s_axis_tdata[ADDR_LO_LSB +: ADDR_W]),
    .mask_hi     (s_axis_tdata[MASK_HI_LSB +: ADDR_W]),
    .mask_lo     (s_axis_tdata[MASK_LO_LSB +: ADDR_W]),
    .out_ready   (m_axis_tready),
    .out_valid   (m_axis_tvalid),
    .out_blocked (blocked)
  );

  // Pad the result beat with zeros.
  assign m_axis_tdata = {{(M_TDATA_W - 1){1'b0}}, blocked};

endmodule

// File: sv/pbm_checker.sv
// Port-level checks of the prefix blocklist matcher and their bind.
module pbm_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [pbm_pkg::S_TUSER_W-1:0] s_axis_tuser,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [pbm_pkg::M_TDATA_W-1:0] m_axis_tdata
);
  import pbm_pkg::*;

  logic q_beat;
  logic l_beat;

  assign q_beat = s_axis_tvalid && s_axis_tready && s_axis_tuser[TUSER_ACTION] == ACT_QUERY;
  assign l_beat = s_axis_tvalid && s_axis_tready && s_axis_tuser[TUSER_ACTION] == ACT_LOAD;

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // A query keeps the input closed while the table is scanned.
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    q_beat |=> !s_axis_tready)
    else $error("input ready right after a query beat");

  // A load never produces a result.
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    l_beat && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("result appeared after a load beat");

  // Padding bits stay zero.
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[M_TDATA_W-1:1] == '0)
    else $error("nonzero padding in result beat");

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind prefix_blocklist_matcher_core pbm_checker u_pbm_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// File: verif/testbench.sv
// Self-checking testbench for the prefix blocklist matcher core over its stream ports.
`timescale 1ns / 1ps

module testbench;
  import pbm_pkg::*;

  localparam int unsigned TABLE_DEPTH    = 16;
  localparam int unsigned RESET_CYCLES   = 5;
  // Leave margin after the longest query, a scan of all TABLE_DEPTH slots, before touching entry_count.
  localparam int unsigned SETTLE_CYCLES  = TABLE_DEPTH + 8;
  localparam int unsigned RANDOM_BEATS   = 170;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned MAX_REPORTS    = 10;

  // One input beat in field form.
  typedef struct packed {
    pbm_action_t         action;
    logic [SLOT_W-1:0]   slot;
    pbm_version_t        version;
    logic [ADDR_W-1:0]   addr_hi;
    logic [ADDR_W-1:0]   addr_lo;
    logic [ADDR_W-1:0]   mask_hi;
    logic [ADDR_W-1:0]   mask_lo;
  } beat_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [S_TUSER_W-1:0]  s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  logic                  cfg_wen = 1'b0;
  logic [COUNT_W-1:0]    cfg_wdata = '0;

  // Shadow copy of the block's table and register.
  pbm_entry_t            prefix_table [TABLE_DEPTH];
  logic [COUNT_W-1:0]    entries_in_use = '0;
  logic                  blocked_expect_q [$];

  int unsigned           send_idle_pct = 0;
  int unsigned           recv_stall_pct = 0;
  int unsigned           mismatches = 0;
  int unsigned           loads_sent = 0;
  int unsigned           queries_sent = 0;
  int unsigned           blocked_seen = 0;
  int unsigned           count_settings = 0;
  int unsigned           idle_cycles = 0;
  logic                  want_blocked;

  always #1 clk = ~clk;

  prefix_blocklist_matcher_core #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Scan the slots in use; IPv4 compares only the low 32 bits of the low half.
  function automatic logic predict_blocked(pbm_version_t ver, logic [ADDR_W-1:0] a_hi,
                                           logic [ADDR_W-1:0] a_lo);
    int unsigned n;
    logic hit;
    n = (entries_in_use > TABLE_DEPTH) ? TABLE_DEPTH : entries_in_use;
    hit = 1'b0;
    for (int unsigned i = 0; i < n; i++) begin
      if (prefix_table[i].version == ver) begin
        if (ver == VER_V4) begin
          if ((a_lo[V4_W-1:0] & prefix_table[i].mask_lo[V4_W-1:0]) ==
              prefix_table[i].net_lo[V4_W-1:0])
            hit = 1'b1;
        end else if ((a_hi & prefix_table[i].mask_hi) == prefix_table[i].net_hi &&
                     (a_lo & prefix_table[i].mask_lo) == prefix_table[i].net_lo) begin
          hit = 1'b1;
        end
      end
    end
    return hit;
  endfunction

  // Update the shadow table on a load, queue the expected flag on a query.
  task automatic apply_beat(input beat_t b);
    logic hit;
    if (b.action == ACT_LOAD) begin
      prefix_table[b.slot].version = b.version;
      prefix_table[b.slot].net_hi  = b.addr_hi;
      prefix_table[b.slot].net_lo  = b.addr_lo;
      prefix_table[b.slot].mask_hi = b.mask_hi;
      prefix_table[b.slot].mask_lo = b.mask_lo;
      loads_sent++;
    end else begin
      hit = predict_blocked(b.version, b.addr_hi, b.addr_lo);
      blocked_expect_q.push_back(hit);
      queries_sent++;
      if (hit) blocked_seen++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Beat builders
  // ---------------------------------------------------------------------------

  function automatic beat_t random_beat();
    beat_t b;
    b.action  = pbm_action_t'($urandom_range(1));
    b.slot    = SLOT_W'($urandom_range(TABLE_DEPTH - 1));
    b.version = pbm_version_t'($urandom_range(1));
    b.addr_hi = {$urandom, $urandom};
    b.addr_lo = {$urandom, $urandom};
    b.mask_hi = {$urandom, $urandom};
    b.mask_lo = {$urandom, $urandom};
    return b;
  endfunction

  function automatic beat_t make_beat(pbm_action_t act, logic [SLOT_W-1:0] slot,
                                      pbm_version_t ver,
                                      logic [ADDR_W-1:0] a_hi, logic [ADDR_W-1:0] a_lo,
                                      logic [ADDR_W-1:0] m_hi, logic [ADDR_W-1:0] m_lo);
    beat_t b;
    b.action  = act;
    b.slot    = slot;
    b.version = ver;
    b.addr_hi = a_hi;
    b.addr_lo = a_lo;
    b.mask_hi = m_hi;
    b.mask_lo = m_lo;
    return b;
  endfunction

  // Well-formed prefix load: network address already masked. For IPv4 the unused
  // upper bits stay random, since the block must ignore them.
  function automatic beat_t prefix_load(logic [SLOT_W-1:0] slot, pbm_version_t ver,
                                        int unsigned len);
    beat_t b;
    logic [127:0] m;
    b = random_beat();
    b.action  = ACT_LOAD;
    b.slot    = slot;
    b.version = ver;
    if (ver == VER_V6) begin
      m = ~128'd0 << (128 - len);
      {b.mask_hi, b.mask_lo} = m;
      {b.addr_hi, b.addr_lo} = {b.addr_hi, b.addr_lo} & m;
    end else begin
      m = {96'd0, ~32'd0 << (32 - len)};
      b.mask_lo[V4_W-1:0] = m[V4_W-1:0];
      b.addr_lo[V4_W-1:0] = b.addr_lo[V4_W-1:0] & m[V4_W-1:0];
    end
    return b;
  endfunction

  // Query aimed inside the prefix of one slot; with flip set, invert one masked
  // bit so the address lands just outside it.
  function automatic beat_t aimed_query(int unsigned idx, bit flip);
    beat_t b;
    logic [127:0] m;
    logic [127:0] a;
    int unsigned pos;
    b = random_beat();
    b.action  = ACT_QUERY;
    b.version = prefix_table[idx].version;
    m = {prefix_table[idx].mask_hi, prefix_table[idx].mask_lo};
    if (b.version == VER_V4) m[127:V4_W] = '0;
    a = ({prefix_table[idx].net_hi, prefix_table[idx].net_lo} & m) |
        ({b.addr_hi, b.addr_lo} & ~m);
    if (flip && m != '0) begin
      do pos = $urandom_range(127); while (!m[pos]);
      a[pos] = ~a[pos];
    end
    {b.addr_hi, b.addr_lo} = a;
    return b;
  endfunction

  // Mostly well-formed loads and queries aimed at live prefixes; the rest is
  // raw noise loads and random or extreme query addresses.
  function automatic beat_t next_random_beat();
    beat_t b;
    int unsigned n;
    int unsigned idx;
    int unsigned pick;
    int unsigned len;
    pbm_version_t ver;
    n = (entries_in_use > TABLE_DEPTH) ? TABLE_DEPTH : entries_in_use;
    if (n < TABLE_DEPTH && $urandom_range(4) == 0) idx = $urandom_range(TABLE_DEPTH - 1, n);
    else if (n == 0) idx = $urandom_range(TABLE_DEPTH - 1);
    else idx = $urandom_range(n - 1);
    pick = $urandom_range(99);
    if (pick < 15) begin
      ver = pbm_version_t'($urandom_range(1));
      if ($urandom_range(32) == 0) len = 0;
      else len = (ver == VER_V6) ? $urandom_range(128, 1) : $urandom_range(32, 1);
      b = prefix_load(SLOT_W'($urandom_range(TABLE_DEPTH - 1)), ver, len);
    end else if (pick < 20) begin
      b = random_beat();
      b.action = ACT_LOAD;
    end else if (pick < 60) begin
      b = aimed_query(idx, 1'b0);
    end else if (pick < 75) begin
      b = aimed_query(idx, 1'b1);
    end else begin
      b = random_beat();
      b.action = ACT_QUERY;
      if (pick >= 95) {b.addr_hi, b.addr_lo} = {128{pick[0]}};
    end
    return b;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus plumbing
  // ---------------------------------------------------------------------------

  // Present one beat and hold it until accepted. Valid stays high afterward so
  // back-to-back beats never drop it; a gap lowers it first.
  task automatic send_beat(input beat_t b);
    int unsigned gap;
    gap = 0;
    while (gap < 200 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    // upper pad bits are zero
    s_axis_tdata  <= {4'd0, b.mask_lo, b.mask_hi, b.addr_lo, b.addr_hi, b.slot};
    s_axis_tuser  <= {b.version, b.action};
    do @(posedge clk); while (!s_axis_tready);
    apply_beat(b);
  endtask

  // Drop valid, wait for every pending flag, then let the scan pipeline empty.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (blocked_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_entry_count(input logic [COUNT_W-1:0] value);
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    entries_in_use = value;
    count_settings++;
  endtask

  // ---------------------------------------------------------------------------
  // Result checking, receiver stalls and watchdog
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("mismatch at %0t: %s", $realtime, what);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      if (m_axis_tvalid && m_axis_tready) begin
        if (blocked_expect_q.size() == 0) begin
          report_mismatch($sformatf("result beat with no query pending, blocked=%0b",
                                    m_axis_tdata[0]));
        end else begin
          want_blocked = blocked_expect_q.pop_front();
          if (m_axis_tdata[0] !== want_blocked)
            report_mismatch($sformatf("blocked expected %0b, got %0b",
                                      want_blocked, m_axis_tdata[0]));
        end
      end
    end
  end

  // Count cycles in which neither side moves a beat; a stuck block ends the run.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
        $display("testbench failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // entry_count is zero out of reset: every query must come back clear.
  task automatic test_empty_table();
    send_beat(make_beat(ACT_QUERY, '1, VER_V4, '1, '1, '1, '1));
    send_beat(make_beat(ACT_QUERY, '0, VER_V6, '0, '0, '0, '0));
  endtask

  // Fill every slot so later scans never touch an unwritten entry.
  task automatic test_load_table();
    // 10.0.0.0/8
    send_beat(make_beat(ACT_LOAD, 4'd0, VER_V4, '0, 64'h0A00_0000,
                        '0, 64'hFF00_0000));
    // 2001:db8::/32
    send_beat(make_beat(ACT_LOAD, 4'd1, VER_V6, 64'h2001_0DB8_0000_0000, '0,
                        64'hFFFF_FFFF_0000_0000, '0));
    // host 192.168.1.1/32 with junk in the unused upper bits
    send_beat(make_beat(ACT_LOAD, 4'd2, VER_V4, '1, 64'hFFFF_FFFF_C0A8_0101, '1, '1));
    // all-ones /128
    send_beat(make_beat(ACT_LOAD, 4'd3, VER_V6, '1, '1, '1, '1));
    // stored address has a bit outside its mask: can never match
    send_beat(make_beat(ACT_LOAD, 4'd4, VER_V4, '0, 64'h0B00_0001, '0, 64'hFF00_0000));
    for (int unsigned s = 5; s < TABLE_DEPTH - 1; s++)
      send_beat(prefix_load(SLOT_W'(s), pbm_version_t'($urandom_range(1)),
                            $urandom_range(32, 8)));
    // IPv6 default route in the last slot: matches any IPv6 address
    send_beat(make_beat(ACT_LOAD, 4'(TABLE_DEPTH - 1), VER_V6, '0, '0, '0, '0));
  endtask

  // Full table, count above depth, and a one-entry table.
  task automatic test_count_extremes();
    settle();
    write_entry_count(COUNT_W'(TABLE_DEPTH));
    send_beat(make_beat(ACT_QUERY, '0, VER_V4, '0, 64'h0A01_0203, '0, '0));
    send_beat(make_beat(ACT_QUERY, '0, VER_V6, 64'h2001_0DB8_FFFF_0000, 64'h1, '0, '0));
    send_beat(make_beat(ACT_QUERY, '1, VER_V4, '1, 64'h1234_5678_C0A8_0101, '1, '1));
    send_beat(make_beat(ACT_QUERY, '0, VER_V4, '0, 64'h0B00_0001, '0, '0));
    settle();
    write_entry_count('1);
    send_beat(make_beat(ACT_QUERY, '0, VER_V6, '1, '1, '0, '0));
    settle();
    write_entry_count(COUNT_W'(1));
    send_beat(make_beat(ACT_QUERY, '0, VER_V4, '0, 64'h0AC8_0001, '0, '0));
    send_beat(make_beat(ACT_QUERY, '0, VER_V6, 64'h2001_0DB8_0000_0000, 64'h1, '0, '0));
  endtask

  // Two table sizes per idling mode, random traffic under each.
  task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct,
                                     input logic [COUNT_W-1:0] count_a,
                                     input logic [COUNT_W-1:0] count_b);
    settle();
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    write_entry_count(count_a);
    repeat (RANDOM_BEATS) send_beat(next_random_beat());
    settle();
    write_entry_count(count_b);
    repeat (RANDOM_BEATS) send_beat(next_random_beat());
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    test_empty_table();
    test_load_table();
    test_count_extremes();
    test_random_traffic(0, 0, COUNT_W'(TABLE_DEPTH), '0);
    test_random_traffic(61, 0, '1, COUNT_W'(1));
    test_random_traffic(0, 61, COUNT_W'(TABLE_DEPTH), COUNT_W'($urandom_range(TABLE_DEPTH)));
    test_random_traffic(24, 24, COUNT_W'(8), COUNT_W'($urandom_range(TABLE_DEPTH)));
    settle();
    $display("covered %0d table loads and %0d queries (%0d blocked) across %0d table sizes,",
             loads_sent, queries_sent, blocked_seen, count_settings);
    $display("with sender gaps and result back-pressure mixed in; %0d mismatches", mismatches);
    if (mismatches == 0 && blocked_expect_q.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// File: files.f
sv/pbm_pkg.sv
sv/pbm_ctrl.sv
sv/pbm_datapath.sv
sv/prefix_blocklist_matcher_core.sv
sv/pbm_checker.sv
verif/testbench.sv
